// ----- rtl/oslin_pkg.sv -----
`default_nettype none

package oslin_pkg;

	// default note count (keys of a full keyboard)
	localparam int NOTES_DEF = 88;

	// widths of the datapath
	localparam int SMP_W  = 16;
	localparam int CH_W   = 8;
	localparam int LOG_W  = 21;
	localparam int GAIN_W = 32;
	localparam int OFS_W  = 24;
	localparam int REG_W  = 16;

	// gain codes: -1.0 marks a note without calibration
	localparam logic signed [GAIN_W-1:0] GAIN_UNSET = -32'sd65536;
	localparam logic signed [GAIN_W-1:0] GAIN_MAX   = 32'sh7FFF_FFFF;

	// configuration register indexes
	localparam logic [1:0] REG_PEAK  = 2'd0;
	localparam logic [1:0] REG_MGAIN = 2'd1;
	localparam logic [1:0] REG_MOFS  = 2'd2;
	localparam logic [1:0] REG_REST  = 2'd3;

	// configuration reset values
	localparam logic [REG_W-1:0] PEAK_RST  = 16'd3277;
	localparam logic [REG_W-1:0] MGAIN_RST = 16'd256;
	localparam logic [REG_W-1:0] MOFS_RST  = 16'd0;
	localparam logic [REG_W-1:0] REST_RST  = 16'd24576;

	// per-note calibration record
	typedef struct packed {
		logic signed [SMP_W-1:0]  max_level;
		logic signed [SMP_W-1:0]  min_level;
		logic signed [GAIN_W-1:0] active_gain;
		logic signed [OFS_W-1:0]  active_offset;
		logic signed [GAIN_W-1:0] staged_gain;
		logic signed [OFS_W-1:0]  staged_offset;
		logic                     max_seen;
		logic                     min_seen;
	} rec_t;

	localparam rec_t REC_RESET = '{
		max_level:     16'sd0,
		min_level:     16'sd16384,
		active_gain:   GAIN_UNSET,
		active_offset: 24'sd0,
		staged_gain:   GAIN_UNSET,
		staged_offset: 24'sd0,
		max_seen:      1'b0,
		min_seen:      1'b0
	};

	// one queued input transaction, classified by the front
	typedef struct packed {
		logic [CH_W-1:0]         channel;
		logic signed [SMP_W-1:0] sample;
		logic                    freeze;
		logic                    dis;
		logic                    is_key;
	} item_t;

	// configuration register set
	typedef struct packed {
		logic signed [REG_W-1:0] peak_threshold;
		logic signed [REG_W-1:0] trim_gain;
		logic signed [REG_W-1:0] trim_offset;
		logic [REG_W-1:0]        rest_factor;
	} cfg_t;

endpackage

`default_nettype wire

// ----- rtl/oslin_ram.sv -----
`default_nettype none

module oslin_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0]      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/oslin_log2.sv -----
`default_nettype none

// Iterative log2 in signed Q.16: one squaring per cycle, 16 fraction bits.
module oslin_log2
	import oslin_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [SMP_W-1:0] x,
	output logic                         done,
	output logic signed [LOG_W-1:0]      result
);

	logic [15:0] m_q;
	logic [15:0] frac_q;
	logic [3:0]  exp_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [14:0] xc;
	logic [3:0]  e;
	logic [15:0] m_init;
	logic [31:0] sq;
	logic [16:0] m2;
	logic [15:0] m_nxt;
	logic signed [4:0] e_off;

	// clamp to 1 LSB and find the leading one
	always_comb begin
		xc = (x < 16'sd1) ? 15'd1 : x[14:0];
		e = 4'd0;
		for (int i = 1; i < 15; i++) begin
			if (xc[i]) begin
				e = 4'(i);
			end
		end
		m_init = 16'(xc) << (4'd15 - e);
	end

	// one squaring step
	assign sq    = m_q * m_q;
	assign m2    = sq[31:15];
	assign m_nxt = m2[16] ? m2[16:1] : m2[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			m_q    <= '0;
			frac_q <= '0;
			exp_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				m_q    <= m_init;
				exp_q  <= e;
				frac_q <= '0;
			end else if (busy_q) begin
				m_q    <= m_nxt;
				frac_q <= {frac_q[14:0], m2[16]};
				cnt_q  <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign e_off  = $signed({1'b0, exp_q}) - 5'sd14;
	assign result = {e_off, frac_q};
	assign done   = done_q;

endmodule

`default_nettype wire

// ----- rtl/oslin_div.sv -----
`default_nettype none

// Restoring divider for 2^32 / d, one quotient bit per cycle.
module oslin_div
	import oslin_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [LOG_W-1:0] d,
	output logic                  done,
	output logic [32:0]           q
);

	logic [LOG_W:0]   rem_q;
	logic [LOG_W-1:0] d_q;
	logic [32:0]      q_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [LOG_W:0] sh;
	logic           qbit;
	logic [LOG_W:0] rem_nxt;

	// only the top dividend bit is set
	always_comb begin
		sh      = {rem_q[LOG_W-1:0], (cnt_q == 6'd32)};
		qbit    = (sh >= {1'b0, d_q});
		rem_nxt = qbit ? (sh - {1'b0, d_q}) : sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			d_q    <= '0;
			q_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
				rem_q  <= '0;
				d_q    <= d;
				q_q    <= '0;
			end else if (busy_q) begin
				rem_q <= rem_nxt;
				q_q   <= {q_q[31:0], qbit};
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign q    = q_q;

endmodule

`default_nettype wire

// ----- rtl/oslin_front.sv -----
`default_nettype none

// Accepts input transactions, tags key channels, queues two deep.
module oslin_front
	import oslin_pkg::*;
#(
	parameter int NOTE_COUNT = NOTES_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [CH_W-1:0]         channel,
	input  wire logic signed [SMP_W-1:0] sample,
	input  wire logic                    freeze,
	input  wire logic                    disable_reset,
	output item_t                        head,
	output logic                         head_valid,
	input  wire logic                    pop
);

	item_t      slot_q [2];
	logic [1:0] cnt_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic       push;
	item_t      incoming;

	// classify
	always_comb begin
		incoming.channel = channel;
		incoming.sample  = sample;
		incoming.freeze  = freeze;
		incoming.dis     = disable_reset;
		incoming.is_key  = ({1'b0, channel} < 9'(NOTE_COUNT));
	end

	assign in_stall   = (cnt_q == 2'd2);
	assign push       = in_valid && !in_stall;
	assign head_valid = (cnt_q != 2'd0);
	assign head       = slot_q[rd_ptr_q];

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= incoming;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/oslin_back.sv -----
`default_nettype none

// Per-item sequencer: record fetch, log2, linearize, restage, write-back.
module oslin_back
	import oslin_pkg::*;
#(
	parameter int NOTE_COUNT = NOTES_DEF,
	localparam int NIDX_W = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1,
	localparam int CNT_W  = $clog2(NOTE_COUNT + 1)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire cfg_t            cfg,
	input  wire item_t           head,
	input  wire logic            head_valid,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [SMP_W-1:0]     out_value,
	output logic [CH_W-1:0]      channel_echo,
	output logic                 note_calibrated,
	output logic                 all_calibrated
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MERGE = 4'd1;
	localparam logic [3:0] S_LOG   = 4'd2;
	localparam logic [3:0] S_L1    = 4'd3;
	localparam logic [3:0] S_L2    = 4'd4;
	localparam logic [3:0] S_L3    = 4'd5;
	localparam logic [3:0] S_DIV   = 4'd6;
	localparam logic [3:0] S_FIN   = 4'd7;

	localparam logic signed [24:0] Y_MAX = {1'b0, {24{1'b1}}};
	localparam logic signed [24:0] Y_MIN = {1'b1, 24'd0};

	logic [3:0]        state_q;
	item_t             item_q;
	logic [NIDX_W-1:0] idx_q;
	rec_t              old_q;
	rec_t              new_q;
	logic              recomp_q;

	logic signed [40:0] pa_s1;
	logic signed [41:0] pb_s1;
	logic signed [24:0] y_s2;
	logic signed [40:0] prod_s3;

	logic                  out_valid_q;
	logic [SMP_W-1:0]      out_value_q;
	logic [CH_W-1:0]       echo_q;
	logic                  note_ok_q;
	logic                  all_ok_q;
	logic [NOTE_COUNT-1:0] vld_q;
	logic [NOTE_COUNT-1:0] cal_q;
	logic [CNT_W-1:0]      cal_cnt_q;

	// record store
	rec_t              rd_data;
	logic              ram_we;
	rec_t              ram_wdata;
	logic [NIDX_W-1:0] ram_raddr;

	assign ram_raddr = head.channel[NIDX_W-1:0];

	oslin_ram #(
		.WIDTH($bits(rec_t)),
		.DEPTH(NOTE_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	// merge and learn: min/max update on the fetched record
	rec_t r;
	rec_t rn;
	logic hit_max;
	logic hit_min;
	logic recomp;

	always_comb begin
		r = REC_RESET;
		if (item_q.is_key && vld_q[idx_q]) begin
			r = rd_data;
		end
		hit_max = (item_q.sample > r.max_level) && (item_q.sample > cfg.peak_threshold);
		hit_min = !hit_max && (item_q.sample < r.min_level);
		rn = r;
		if (hit_max) begin
			rn.max_level = item_q.sample;
			rn.max_seen  = 1'b1;
		end else if (hit_min) begin
			rn.min_level = item_q.sample;
			rn.min_seen  = 1'b1;
		end
		recomp = (hit_max || hit_min) && rn.max_seen && rn.min_seen && !item_q.freeze;
	end

	// three log units run side by side
	logic                    log_start;
	logic                    lx_done;
	logic                    lmax_done;
	logic                    lmin_done;
	logic signed [LOG_W-1:0] lx;
	logic signed [LOG_W-1:0] lmax;
	logic signed [LOG_W-1:0] lmin;

	assign log_start = (state_q == S_MERGE) && item_q.is_key && !item_q.dis;

	oslin_log2 u_log_x (
		.clk(clk), .arst_n(arst_n), .start(log_start), .x(item_q.sample),
		.done(lx_done), .result(lx)
	);
	oslin_log2 u_log_max (
		.clk(clk), .arst_n(arst_n), .start(log_start), .x(rn.max_level),
		.done(lmax_done), .result(lmax)
	);
	oslin_log2 u_log_min (
		.clk(clk), .arst_n(arst_n), .start(log_start), .x(rn.min_level),
		.done(lmin_done), .result(lmin)
	);

	// reciprocal of the log span
	logic signed [LOG_W:0] d;
	logic                  div_start;
	logic                  div_done;
	logic [32:0]           div_q;

	assign d         = {lmax[LOG_W-1], lmax} - {lmin[LOG_W-1], lmin};
	assign div_start = (state_q == S_L3) && recomp_q;

	oslin_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .d(d[LOG_W-1:0]),
		.done(div_done), .q(div_q)
	);

	// linearize datapath
	logic signed [24:0] t;
	logic signed [15:0] ghi;
	logic signed [16:0] glo;
	logic signed [63:0] p;
	logic signed [45:0] y46;
	logic signed [24:0] yc;
	logic signed [40:0] prod;
	logic signed [32:0] zs;
	logic [SMP_W-1:0]   z;

	always_comb begin
		t   = 25'(lx) - 25'(old_q.active_offset);
		ghi = old_q.active_gain[31:16];
		glo = {1'b0, old_q.active_gain[15:0]};
		p   = (64'(pa_s1) <<< 16) + 64'(pb_s1);
		y46 = 46'(p >>> 18);
		if (y46 > 46'(Y_MAX)) begin
			yc = Y_MAX;
		end else if (y46 < 46'(Y_MIN)) begin
			yc = Y_MIN;
		end else begin
			yc = y46[24:0];
		end
		prod = y_s2 * cfg.trim_gain;
		zs   = 33'(prod_s3 >>> 8) + 33'(cfg.trim_offset);
		if (zs > 33'sd32767) begin
			z = 16'h7FFF;
		end else if (zs < -33'sd32768) begin
			z = 16'h8000;
		end else begin
			z = zs[15:0];
		end
	end

	// restage, rest test and final record
	logic signed [GAIN_W-1:0] sg;
	logic signed [16:0]       rf_s;
	logic signed [32:0]       rest_r;
	logic signed [33:0]       rest_l;
	rec_t                     f;
	logic signed [GAIN_W-1:0] fin_gain;
	logic                     note_ok;
	logic [SMP_W-1:0]         y_out;
	logic                     out_free;
	logic                     fin;
	logic [CNT_W-1:0]         cal_cnt_nxt;

	always_comb begin
		if (d < 0) begin
			sg = GAIN_UNSET;
		end else if (d <= 2) begin
			sg = GAIN_MAX;
		end else begin
			sg = div_q[31:0];
		end
		f = new_q;
		if (recomp_q) begin
			f.staged_gain   = sg;
			f.staged_offset = 24'(lmin);
		end
		rf_s   = {1'b0, cfg.rest_factor};
		rest_r = rf_s * f.min_level;
		rest_l = 34'(item_q.sample) <<< 14;
		if (rest_l < 34'(rest_r)) begin
			f.active_gain   = f.staged_gain;
			f.active_offset = f.staged_offset;
		end

		if (item_q.dis) begin
			fin_gain = GAIN_UNSET;
		end else if (item_q.freeze) begin
			fin_gain = old_q.active_gain;
		end else begin
			fin_gain = f.active_gain;
		end
		note_ok = item_q.is_key && (fin_gain > 0);

		if (item_q.is_key && !item_q.dis && (old_q.active_gain > 0)) begin
			y_out = z;
		end else begin
			y_out = item_q.sample;
		end

		out_free  = !out_valid_q || !out_stall;
		fin       = (state_q == S_FIN) && out_free;
		ram_we    = fin && item_q.is_key && (item_q.dis || !item_q.freeze);
		ram_wdata = item_q.dis ? REC_RESET : f;

		cal_cnt_nxt = cal_cnt_q;
		if (item_q.is_key) begin
			if (note_ok && !cal_q[idx_q]) begin
				cal_cnt_nxt = cal_cnt_q + CNT_W'(1);
			end else if (!note_ok && cal_q[idx_q]) begin
				cal_cnt_nxt = cal_cnt_q - CNT_W'(1);
			end
		end
	end

	assign pop = (state_q == S_IDLE) && head_valid;

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			vld_q       <= '0;
			cal_q       <= '0;
			cal_cnt_q   <= '0;
			recomp_q    <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						state_q <= S_MERGE;
					end
				end
				S_MERGE: begin
					recomp_q <= recomp;
					if (item_q.is_key && !item_q.dis) begin
						state_q <= S_LOG;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_LOG: begin
					if (lx_done) begin
						state_q <= S_L1;
					end
				end
				S_L1: state_q <= S_L2;
				S_L2: state_q <= S_L3;
				S_L3: state_q <= recomp_q ? S_DIV : S_FIN;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (item_q.is_key) begin
							cal_q[idx_q] <= note_ok;
							cal_cnt_q    <= cal_cnt_nxt;
						end
						if (ram_we) begin
							vld_q[idx_q] <= 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
			idx_q  <= head.channel[NIDX_W-1:0];
		end
		if (state_q == S_MERGE) begin
			old_q <= r;
			new_q <= rn;
		end
		pa_s1   <= t * ghi;
		pb_s1   <= t * glo;
		y_s2    <= yc;
		prod_s3 <= prod;
		if (fin) begin
			out_value_q <= y_out;
			echo_q      <= item_q.channel;
			note_ok_q   <= note_ok;
			all_ok_q    <= (cal_cnt_nxt == CNT_W'(NOTE_COUNT));
		end
	end

	assign out_valid       = out_valid_q;
	assign out_value       = out_value_q;
	assign channel_echo    = echo_q;
	assign note_calibrated = note_ok_q;
	assign all_calibrated  = all_ok_q;

`ifndef SYNTH
	// calibrated count tracks the per-note flags
	a_cal_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cal_q) == int'(cal_cnt_q))
		else $error("calibrated count out of step with flags");

	// queue is drained only from idle
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == S_IDLE))
		else $error("pop outside idle");

	// a held result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> $stable(out_value_q))
		else $error("stalled result changed");

	// log units finish together
	a_log_sync: assert property (@(posedge clk) disable iff (!arst_n)
		lx_done |-> (lmax_done && lmin_done))
		else $error("log units out of step");
`endif

endmodule

`default_nettype wire

// ----- rtl/optical_sensor_log_linearizer_core.sv -----
`default_nettype none

// Channel   Handshake          Payload
// input     in_valid/in_stall  channel, sample, freeze, disable_reset
// output    out_valid/out_stall out_value, channel_echo, note_calibrated, all_calibrated
// config    cfg_we             cfg_index, cfg_data
//
// Non-key or disable transactions go from the merge state straight to the final one;
// a key sample also runs the 16-step squaring log2 loop and the linearize steps;
// when min/max restage the gain, the bit-serial reciprocal divider runs as well.
// Reset clears all calibration records and loads the configuration defaults.
// Two input transactions queue while the back end works or the output stalls.

module optical_sensor_log_linearizer_core
	import oslin_pkg::*;
#(
	parameter int NOTE_COUNT = NOTES_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [CH_W-1:0]         channel,
	input  wire logic signed [SMP_W-1:0] sample,
	input  wire logic                    freeze,
	input  wire logic                    disable_reset,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic signed [SMP_W-1:0]      out_value,
	output logic [CH_W-1:0]              channel_echo,
	output logic                         note_calibrated,
	output logic                         all_calibrated,
	input  wire logic                    cfg_we,
	input  wire logic [1:0]              cfg_index,
	input  wire logic [REG_W-1:0]        cfg_data
);

	cfg_t  cfg_q;
	item_t head;
	logic  head_valid;
	logic  pop;
	logic [SMP_W-1:0] out_value_u;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.peak_threshold <= PEAK_RST;
			cfg_q.trim_gain      <= MGAIN_RST;
			cfg_q.trim_offset    <= MOFS_RST;
			cfg_q.rest_factor    <= REST_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PEAK:  cfg_q.peak_threshold <= cfg_data;
				REG_MGAIN: cfg_q.trim_gain      <= cfg_data;
				REG_MOFS:  cfg_q.trim_offset    <= cfg_data;
				REG_REST:  cfg_q.rest_factor    <= cfg_data;
				default:   cfg_q <= cfg_q;
			endcase
		end
	end

	oslin_front #(
		.NOTE_COUNT(NOTE_COUNT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.channel      (channel),
		.sample       (sample),
		.freeze       (freeze),
		.disable_reset(disable_reset),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop)
	);

	oslin_back #(
		.NOTE_COUNT(NOTE_COUNT)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.head           (head),
		.head_valid     (head_valid),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_value      (out_value_u),
		.channel_echo   (channel_echo),
		.note_calibrated(note_calibrated),
		.all_calibrated (all_calibrated)
	);

	assign out_value = $signed(out_value_u);

endmodule

`default_nettype wire

// ----- verif/oslin_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels and the register port, predicts every result of the
// linearizer and compares it with what the block returns.
module oslin_checker
	import oslin_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	input  wire logic                    in_stall,
	input  wire logic [CH_W-1:0]         channel,
	input  wire logic signed [SMP_W-1:0] sample,
	input  wire logic                    freeze,
	input  wire logic                    disable_reset,
	input  wire logic                    out_valid,
	input  wire logic                    out_stall,
	input  wire logic signed [SMP_W-1:0] out_value,
	input  wire logic [CH_W-1:0]         channel_echo,
	input  wire logic                    note_calibrated,
	input  wire logic                    all_calibrated,
	input  wire logic                    cfg_we,
	input  wire logic [1:0]              cfg_index,
	input  wire logic [REG_W-1:0]        cfg_data,
	output int                           mismatches,
	output int                           waiting
);

	typedef struct {
		logic signed [SMP_W-1:0] value;
		logic [CH_W-1:0]         ch;
		logic                    note_ok;
		logic                    all_ok;
	} lin_result_t;

	lin_result_t pending_results[$];

	// predicted calibration records and register copies
	int  max_lvl[NOTES_DEF];
	int  min_lvl[NOTES_DEF];
	longint act_gain[NOTES_DEF];
	longint act_ofs[NOTES_DEF];
	longint stg_gain[NOTES_DEF];
	longint stg_ofs[NOTES_DEF];
	bit  max_hit[NOTES_DEF];
	bit  min_hit[NOTES_DEF];
	cfg_t regs;

	assign waiting = pending_results.size();

	// truncated log2 in 16 fraction bits, by repeated squaring
	function automatic int log2_fix(input int x);
		int v;
		int e;
		longint m;
		int frac;
		v = (x < 1) ? 1 : x;
		v = v & 32'h7FFF;
		if (v == 0) begin
			v = 1;
		end
		e = 0;
		frac = 0;
		while (e < 14 && (v >> (e + 1)) != 0) begin
			e++;
		end
		m = longint'(v) << (15 - e);
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 15;
			frac = frac << 1;
			if (m >= 65536) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		return (e - 14) * 65536 + frac;
	endfunction

	// reciprocal of the log span between min and max
	function automatic longint span_gain(input int lo, input int hi);
		longint d;
		longint q;
		d = longint'(log2_fix(hi)) - longint'(log2_fix(lo));
		if (d < 0) begin
			return longint'(GAIN_UNSET);
		end
		if (d == 0) begin
			return longint'(GAIN_MAX);
		end
		q = (64'sd1 << 32) / d;
		if (q > longint'(GAIN_MAX)) begin
			q = longint'(GAIN_MAX);
		end
		return q;
	endfunction

	function automatic void clear_note(input int n);
		max_lvl[n] = 0;
		min_lvl[n] = 16384;
		act_gain[n] = longint'(GAIN_UNSET);
		act_ofs[n] = 0;
		stg_gain[n] = longint'(GAIN_UNSET);
		stg_ofs[n] = 0;
		max_hit[n] = 0;
		min_hit[n] = 0;
	endfunction

	function automatic int linearized(input int n, input int x);
		longint t;
		longint y;
		longint z;
		t = longint'(log2_fix(x)) - act_ofs[n];
		y = (t * act_gain[n]) >>> 18;
		z = ((y * longint'(regs.trim_gain)) >>> 8) + longint'(regs.trim_offset);
		if (z > 32767) begin
			z = 32767;
		end
		if (z < -32768) begin
			z = -32768;
		end
		return int'(z);
	endfunction

	// min/max tracking, restaging and the at-rest swap
	function automatic void track_levels(input int n, input int x);
		bit fresh;
		fresh = 0;
		if (x > max_lvl[n] && x > int'(regs.peak_threshold)) begin
			max_lvl[n] = x;
			max_hit[n] = 1;
			fresh = 1;
		end else if (x < min_lvl[n]) begin
			min_lvl[n] = x;
			min_hit[n] = 1;
			fresh = 1;
		end
		if (fresh && max_hit[n] && min_hit[n]) begin
			stg_gain[n] = span_gain(min_lvl[n], max_lvl[n]);
			stg_ofs[n] = log2_fix(min_lvl[n]);
		end
		if (longint'(x) * 16384 < longint'(regs.rest_factor) * longint'(min_lvl[n])) begin
			act_gain[n] = stg_gain[n];
			act_ofs[n] = stg_ofs[n];
		end
	endfunction

	function automatic lin_result_t predict_output(input int ch, input int x,
			input bit frz, input bit dis);
		lin_result_t r;
		r.value = x[15:0];
		r.ch = ch[7:0];
		r.note_ok = 0;
		r.all_ok = 1;
		if (ch < NOTES_DEF) begin
			if (dis) begin
				clear_note(ch);
			end else begin
				if (act_gain[ch] > 0) begin
					r.value = 16'(linearized(ch, x));
				end
				if (!frz) begin
					track_levels(ch, x);
				end
			end
			r.note_ok = act_gain[ch] > 0;
		end
		for (int n = 0; n < NOTES_DEF; n++) begin
			if (act_gain[n] <= 0) begin
				r.all_ok = 0;
			end
		end
		return r;
	endfunction

	// predict on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin
		lin_result_t want;
		if (!arst_n) begin
			for (int n = 0; n < NOTES_DEF; n++) begin
				clear_note(n);
			end
			regs.peak_threshold = PEAK_RST;
			regs.trim_gain = MGAIN_RST;
			regs.trim_offset = MOFS_RST;
			regs.rest_factor = REST_RST;
			pending_results.delete();
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PEAK:  regs.peak_threshold = cfg_data;
					REG_MGAIN: regs.trim_gain = cfg_data;
					REG_MOFS:  regs.trim_offset = cfg_data;
					REG_REST:  regs.rest_factor = cfg_data;
					default:   ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: unexpected result ch %0d value %0d", $realtime,
							channel_echo, out_value);
					end
				end else begin
					want = pending_results.pop_front();
					if (out_value !== want.value || channel_echo !== want.ch ||
							note_calibrated !== want.note_ok ||
							all_calibrated !== want.all_ok) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: exp ch %0d v %0d nc %0b ac %0b, got %0d %0d %0b %0b",
								$realtime, want.ch, want.value, want.note_ok, want.all_ok,
								channel_echo, out_value, note_calibrated, all_calibrated);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				pending_results.push_back(predict_output(int'(channel), int'(sample),
					freeze, disable_reset));
			end
		end
	end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import oslin_pkg::*;

	localparam int QUIET_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 120;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [CH_W-1:0]         channel = '0;
	logic signed [SMP_W-1:0] sample = '0;
	logic                    freeze = 1'b0;
	logic                    disable_reset = 1'b0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [SMP_W-1:0] out_value;
	logic [CH_W-1:0]         channel_echo;
	logic                    note_calibrated;
	logic                    all_calibrated;
	logic                    cfg_we = 1'b0;
	logic [1:0]              cfg_index = REG_PEAK;
	logic [REG_W-1:0]        cfg_data = '0;

	int mismatches;
	int waiting;
	int quiet_cycles = 0;
	int samples_sent = 0;
	int calibrated_seen = 0;
	int all_cal_seen = 0;
	bit idle_on = 1'b1;
	bit squeeze_req = 1'b0;
	int squeeze_left = 0;

	optical_sensor_log_linearizer_core dut (.*);

	oslin_checker u_checker (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (squeeze_req && squeeze_left == 0) begin
			squeeze_req = 1'b0;
			squeeze_left = 400;
		end
		if (squeeze_left > 0) begin
			squeeze_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= idle_on && ($urandom_range(99) < 9);
		end
	end

	// watchdog and a little bookkeeping for the summary
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (out_valid && !out_stall) begin
			calibrated_seen += note_calibrated;
			all_cal_seen += all_calibrated;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout with %0d results outstanding", waiting);
			$display("testbench failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [REG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(input logic [REG_W-1:0] thr, input logic [REG_W-1:0] mg,
			input logic [REG_W-1:0] mo, input logic [REG_W-1:0] rf);
		write_reg(REG_PEAK, thr);
		write_reg(REG_MGAIN, mg);
		write_reg(REG_MOFS, mo);
		write_reg(REG_REST, rf);
	endtask

	// block drained: all results back, then slack for a transaction in flight
	task automatic wait_drained();
		while (waiting != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_sample(input int ch, input int x, input bit frz, input bit dis);
		if (idle_on && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		channel <= ch[7:0];
		sample <= x[15:0];
		freeze <= frz;
		disable_reset <= dis;
		do begin
			@(posedge clk);
		end while (in_stall);
		samples_sent++;
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// mostly press/release shapes on a few keys, with noise and disables
	task automatic send_random(input int count);
		int r;
		int ch;
		int x;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			ch = ($urandom_range(1)) ? $urandom_range(7) : $urandom_range(NOTES_DEF - 1);
			x = $urandom_range(99);
			if (x < 40) begin
				x = $urandom_range(8000, 16384);
			end else if (x < 80) begin
				x = $urandom_range(200, 3000);
			end else begin
				x = $signed(16'($urandom));
			end
			if (r < 8) begin
				send_sample($urandom_range(NOTES_DEF, 255), $signed(16'($urandom)),
					$urandom_range(1), $urandom_range(1));
			end else if (r < 11) begin
				send_sample(ch, x, $urandom_range(1), 1'b1);
			end else begin
				send_sample(ch, x, $urandom_range(99) < 8, 1'b0);
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_regs(16'd16000, 16'd256, 16'd0, 16'd24576);

		// directed: pass-through channels, extremes, min set above a max
		send_sample(255, 0, 1'b0, 1'b0);
		send_sample(NOTES_DEF, -32768, 1'b1, 1'b1);
		send_sample(95, 32767, 1'b0, 1'b0);
		send_sample(96, 1, 1'b0, 1'b0);
		send_sample(2, 15000, 1'b0, 1'b0);
		send_sample(0, 32767, 1'b0, 1'b0);
		send_sample(0, -32768, 1'b0, 1'b0);
		send_sample(0, 0, 1'b0, 1'b0);
		send_sample(0, 16384, 1'b0, 1'b0);
		send_sample(0, 5000, 1'b1, 1'b0);
		send_sample(0, 1, 1'b0, 1'b0);
		send_sample(1, 20000, 1'b0, 1'b0);
		send_sample(1, 20000, 1'b0, 1'b0);
		send_sample(1, 12000, 1'b0, 1'b0);
		send_sample(0, 12000, 1'b0, 1'b1);
		send_sample(0, 12000, 1'b0, 1'b0);
		stop_sending();
		wait_drained();

		// inverted span on key 2, then calibrate every key
		set_regs(16'd3277, 16'd256, 16'd0, 16'd24576);
		send_sample(2, 5000, 1'b0, 1'b0);
		for (int n = 0; n < NOTES_DEF; n++) begin
			send_sample(n, $urandom_range(9000, 16384), 1'b0, 1'b0);
			send_sample(n, $urandom_range(300, 2000), 1'b0, 1'b0);
		end
		squeeze_req = 1'b1;
		send_random(150);
		stop_sending();
		wait_drained();

		set_regs(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF);
		send_random(150);
		stop_sending();
		wait_drained();

		// quiet stretch: no idling on either side
		idle_on = 1'b0;
		set_regs(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000);
		send_random(150);
		stop_sending();
		wait_drained();
		idle_on = 1'b1;

		set_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		send_random(80);
		stop_sending();
		wait_drained();
		set_regs(16'd3277, 16'd256, 16'd0, 16'd24576);
		send_random(80);
		stop_sending();
		wait_drained();

		$display("run covered %0d samples over six register settings", samples_sent);
		$display("results with key calibrated: %0d, with all keys calibrated: %0d",
			calibrated_seen, all_cal_seen);
		if (mismatches == 0 && waiting == 0) begin
			$display("testbench passed");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, waiting);
			$display("testbench failed");
		end
		$finish;
	end

endmodule

// ----- optical_sensor_log_linearizer_core.f -----
rtl/oslin_pkg.sv
rtl/oslin_ram.sv
rtl/oslin_log2.sv
rtl/oslin_div.sv
rtl/oslin_front.sv
rtl/oslin_back.sv
rtl/optical_sensor_log_linearizer_core.sv
verif/oslin_checker.sv
verif/testbench.sv
